>>> rtl/gamepad_deadzone_and_edge_detect_top_macros.svh
// Assertion macros shared by the gamepad conditioner checker.
`ifndef GAMEPAD_DEADZONE_AND_EDGE_DETECT_TOP_MACROS_SVH
`define GAMEPAD_DEADZONE_AND_EDGE_DETECT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GDZ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdz assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define GDZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdz assertion failed");

`endif

>>> rtl/gdz_pkg.sv
// Types and constants shared by the gamepad stick conditioner.
`timescale 1ns / 1ps
package gdz_pkg;

    typedef struct packed {
        logic               pad_present;
        logic [1:0]         pad_index;
        logic signed [15:0] left_raw_x;
        logic signed [15:0] left_raw_y;
        logic signed [15:0] right_raw_x;
        logic signed [15:0] right_raw_y;
        logic [15:0]        button_word;
    } in_t;

    typedef struct packed {
        logic               is_connected;
        logic               just_connected;
        logic               just_disconnected;
        logic [1:0]         active_pad;
        logic signed [15:0] left_out_x;
        logic signed [15:0] left_out_y;
        logic [14:0]        left_magnitude;
        logic signed [15:0] right_out_x;
        logic signed [15:0] right_out_y;
        logic [14:0]        right_magnitude;
        logic [3:0]         press_edges;
    } out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic square;
        logic root_step;
        logic mag_setup;
        logic mag_step;
        logic xy_setup;
        logic xy_step;
        logic finish;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_MAG_SET,
        ST_MAG_DIV,
        ST_XY_SET,
        ST_XY_DIV,
        ST_FINISH
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_LEFT_DZ  = 3'd0;
    localparam logic [2:0] REG_RIGHT_DZ = 3'd1;
    localparam logic [2:0] REG_MASK_0   = 3'd2;
    localparam logic [2:0] REG_MASK_1   = 3'd3;
    localparam logic [2:0] REG_MASK_2   = 3'd4;
    localparam logic [2:0] REG_MASK_3   = 3'd5;

    localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
    localparam logic [15:0] MASK_0_RESET   = 16'd4096;
    localparam logic [15:0] MASK_1_RESET   = 16'd16384;
    localparam logic [15:0] MASK_2_RESET   = 16'd8192;
    localparam logic [15:0] MASK_3_RESET   = 16'd32768;

    // Fixed point: 1.0 == 32767*32768
    localparam logic [29:0] FULL_D = 30'd1073709056;
    localparam logic [29:0] DZ_MAX = 30'd1020023603;
    localparam logic [30:0] EPS_D  = 31'd10737;
    localparam logic [14:0] ONE_Q  = 15'd32767;

    // Iteration counts of the sequential units
    localparam logic [4:0] ROOT_STEPS = 5'd31;
    localparam logic [4:0] MAG_STEPS  = 5'd17;
    localparam logic [4:0] XY_STEPS   = 5'd15;

endpackage

>>> rtl/gdz_ctrl.sv
// Sequencing state machine and output handshake of the conditioner.
`timescale 1ns / 1ps
module gdz_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output gdz_pkg::cmd_t cmd
);

    gdz_pkg::state_t state_reg, state_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    // State, counter and output beat flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdz_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            gdz_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gdz_pkg::ST_SQUARE;
                end
            end
            gdz_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = gdz_pkg::ROOT_STEPS - 5'd1;
                state_next = gdz_pkg::ST_ROOT;
            end
            gdz_pkg::ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = gdz_pkg::ST_MAG_SET;
                end
            end
            gdz_pkg::ST_MAG_SET:
            begin
                cmd.mag_setup = 1'b1;
                cnt_next      = gdz_pkg::MAG_STEPS - 5'd1;
                state_next    = gdz_pkg::ST_MAG_DIV;
            end
            gdz_pkg::ST_MAG_DIV:
            begin
                cmd.mag_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = gdz_pkg::ST_XY_SET;
                end
            end
            gdz_pkg::ST_XY_SET:
            begin
                cmd.xy_setup = 1'b1;
                cnt_next     = gdz_pkg::XY_STEPS - 5'd1;
                state_next   = gdz_pkg::ST_XY_DIV;
            end
            gdz_pkg::ST_XY_DIV:
            begin
                cmd.xy_step = 1'b1;
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = gdz_pkg::ST_FINISH;
                end
            end
            gdz_pkg::ST_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = gdz_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdz_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && out_stall);
    assign in_stall       = (state_reg != gdz_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;

endmodule

>>> rtl/gdz_stick.sv
// One thumbstick lane: normalize, square root, magnitude and direction division.
`timescale 1ns / 1ps
module gdz_stick (
    input  logic               clk,
    input  gdz_pkg::cmd_t      cmd,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic [14:0]        dead_zone,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic [14:0]        magnitude
);

    logic [29:0] ax_reg, ay_reg;
    logic        negx_reg, negy_reg;
    logic [61:0] v_reg, res_reg, bit_reg;
    logic [46:0] num_reg, dsh_reg;
    logic [16:0] q_reg;
    logic [14:0] mag_reg;
    logic        nz_reg;
    logic [45:0] nx_reg, ny_reg, dshr_reg;
    logic [14:0] qx_reg, qy_reg;

    logic signed [16:0] sx, sy;
    logic [16:0] absx, absy;
    logic [29:0] ax_next, ay_next;
    logic [61:0] root_sum;
    logic [30:0] r;
    logic [29:0] dz_full, dz, den;
    logic [30:0] diff;
    logic [14:0] mag_sat;

    // Normalize: negative by 32767, positive by 32768 on the common scale
    always_comb
    begin
        sx      = {raw_x[15], raw_x};
        sy      = {raw_y[15], raw_y};
        absx    = raw_x[15] ? 17'(-sx) : 17'(sx);
        absy    = raw_y[15] ? 17'(-sy) : 17'(sy);
        ax_next = raw_x[15] ? 30'(32'(absx) * 32'd32767) : 30'({absx, 15'b0});
        ay_next = raw_y[15] ? 30'(32'(absy) * 32'd32767) : 30'({absy, 15'b0});
    end

    // Dead zone on the common scale, clamped
    always_comb
    begin
        dz_full  = {dead_zone, 15'b0};
        dz       = (dz_full > gdz_pkg::DZ_MAX) ? gdz_pkg::DZ_MAX : dz_full;
        den      = gdz_pkg::FULL_D - dz;
        r        = res_reg[30:0];
        diff     = r - {1'b0, dz};
        root_sum = res_reg + bit_reg;
        mag_sat  = (q_reg > {2'b0, gdz_pkg::ONE_Q}) ? gdz_pkg::ONE_Q : q_reg[14:0];
    end

    // Datapath registers, stepped by controller commands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            negx_reg <= raw_x[15];
            negy_reg <= raw_y[15];
        end
        if (cmd.square)
        begin
            v_reg   <= 62'(ax_reg) * 62'(ax_reg) + 62'(ay_reg) * 62'(ay_reg);
            res_reg <= '0;
            bit_reg <= 62'(1) << 60;
        end
        if (cmd.root_step)
        begin
            if (v_reg >= root_sum)
            begin
                v_reg   <= v_reg - root_sum;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mag_setup)
        begin
            nz_reg  <= (r > {1'b0, dz}) && (r > gdz_pkg::EPS_D);
            num_reg <= 47'({diff, 15'b0}) - 47'(diff) + 47'(den >> 1);
            dsh_reg <= 47'({den, 16'b0});
            q_reg   <= '0;
        end
        if (cmd.mag_step)
        begin
            if (num_reg >= dsh_reg)
            begin
                num_reg <= num_reg - dsh_reg;
                q_reg   <= {q_reg[15:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[15:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.xy_setup)
        begin
            mag_reg  <= mag_sat;
            nx_reg   <= 46'(ax_reg) * 46'(mag_sat) + 46'(r >> 1);
            ny_reg   <= 46'(ay_reg) * 46'(mag_sat) + 46'(r >> 1);
            dshr_reg <= 46'({r, 14'b0});
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (cmd.xy_step)
        begin
            if (nx_reg >= dshr_reg)
            begin
                nx_reg <= nx_reg - dshr_reg;
                qx_reg <= {qx_reg[13:0], 1'b1};
            end
            else
            begin
                qx_reg <= {qx_reg[13:0], 1'b0};
            end
            if (ny_reg >= dshr_reg)
            begin
                ny_reg <= ny_reg - dshr_reg;
                qy_reg <= {qy_reg[13:0], 1'b1};
            end
            else
            begin
                qy_reg <= {qy_reg[13:0], 1'b0};
            end
            dshr_reg <= dshr_reg >> 1;
        end
    end

    // Signed results, zero inside the dead zone
    always_comb
    begin
        out_x     = '0;
        out_y     = '0;
        magnitude = '0;
        if (nz_reg)
        begin
            out_x     = negx_reg ? 16'(-{1'b0, qx_reg}) : {1'b0, qx_reg};
            out_y     = negy_reg ? 16'(-{1'b0, qy_reg}) : {1'b0, qy_reg};
            magnitude = mag_reg;
        end
    end

endmodule

>>> rtl/gdz_datapath.sv
// Datapath: configuration, connect tracking, button edges, two stick lanes, result register.
`timescale 1ns / 1ps
module gdz_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  gdz_pkg::cmd_t cmd,
    input  gdz_pkg::in_t  in_data,
    input  logic          cfg_write,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output gdz_pkg::out_t out_data
);

    logic [14:0] left_dz_reg, right_dz_reg;
    logic [15:0] mask_reg [4];
    logic [1:0]  last_pad_reg;
    logic        was_present_reg;
    logic [15:0] prior_buttons_reg;

    logic        present_reg, jc_reg, jd_reg;
    logic [1:0]  pad_reg;
    logic [3:0]  edges_reg;
    gdz_pkg::out_t out_reg;

    logic        newly;
    logic [15:0] base;
    logic [3:0]  edges;
    logic signed [15:0] lx, ly, rx, ry;
    logic [14:0] lm, rm;
    gdz_pkg::out_t result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= gdz_pkg::LEFT_DZ_RESET;
            right_dz_reg <= gdz_pkg::RIGHT_DZ_RESET;
            mask_reg[0]  <= gdz_pkg::MASK_0_RESET;
            mask_reg[1]  <= gdz_pkg::MASK_1_RESET;
            mask_reg[2]  <= gdz_pkg::MASK_2_RESET;
            mask_reg[3]  <= gdz_pkg::MASK_3_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gdz_pkg::REG_LEFT_DZ:  left_dz_reg  <= cfg_data[14:0];
                gdz_pkg::REG_RIGHT_DZ: right_dz_reg <= cfg_data[14:0];
                gdz_pkg::REG_MASK_0:   mask_reg[0]  <= cfg_data;
                gdz_pkg::REG_MASK_1:   mask_reg[1]  <= cfg_data;
                gdz_pkg::REG_MASK_2:   mask_reg[2]  <= cfg_data;
                gdz_pkg::REG_MASK_3:   mask_reg[3]  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Connect detection and masked press edges
    always_comb
    begin
        newly = !was_present_reg || (last_pad_reg != in_data.pad_index);
        base  = newly ? in_data.button_word : prior_buttons_reg;
        for (int i = 0; i < 4; i++)
        begin
            edges[i] = (|(in_data.button_word & mask_reg[i])) && !(|(base & mask_reg[i]));
        end
    end

    // Poll history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pad_reg      <= '0;
            was_present_reg   <= 1'b0;
            prior_buttons_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (in_data.pad_present)
            begin
                last_pad_reg      <= in_data.pad_index;
                was_present_reg   <= 1'b1;
                prior_buttons_reg <= in_data.button_word;
            end
            else
            begin
                last_pad_reg      <= '0;
                was_present_reg   <= 1'b0;
                prior_buttons_reg <= '0;
            end
        end
    end

    // Per-beat flags held while the sticks iterate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            present_reg <= in_data.pad_present;
            jc_reg      <= in_data.pad_present && newly;
            jd_reg      <= !in_data.pad_present && was_present_reg;
            pad_reg     <= in_data.pad_present ? in_data.pad_index : 2'd0;
            edges_reg   <= in_data.pad_present ? edges : 4'd0;
        end
    end

    gdz_stick u_left (
        .clk       (clk),
        .cmd       (cmd),
        .raw_x     (in_data.left_raw_x),
        .raw_y     (in_data.left_raw_y),
        .dead_zone (left_dz_reg),
        .out_x     (lx),
        .out_y     (ly),
        .magnitude (lm)
    );

    gdz_stick u_right (
        .clk       (clk),
        .cmd       (cmd),
        .raw_x     (in_data.right_raw_x),
        .raw_y     (in_data.right_raw_y),
        .dead_zone (right_dz_reg),
        .out_x     (rx),
        .out_y     (ry),
        .magnitude (rm)
    );

    // Assemble the result beat
    always_comb
    begin
        result                   = '0;
        result.is_connected      = present_reg;
        result.just_connected    = jc_reg;
        result.just_disconnected = jd_reg;
        result.active_pad        = pad_reg;
        result.press_edges       = edges_reg;
        if (present_reg)
        begin
            result.left_out_x      = lx;
            result.left_out_y      = ly;
            result.left_magnitude  = lm;
            result.right_out_x     = rx;
            result.right_out_y     = ry;
            result.right_magnitude = rm;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= result;
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/gamepad_deadzone_and_edge_detect_top.sv
// An accepted input beat steps through load, square, a 31-step square root, a 17-step
// magnitude divider and a 15-step direction divider in turn, in both stick lanes side by side;
// no new input beat is taken until the result is handed to the output register.
// The output register frees the input side while a result beat waits.
// Reset (rst_n, async, active low) restores register defaults and clears poll history.
`timescale 1ns / 1ps
module gamepad_deadzone_and_edge_detect_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  gdz_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output gdz_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    gdz_pkg::cmd_t cmd;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    gdz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gdz_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

>>> rtl/gdz_checker.sv
// Port-level checks for the gamepad conditioner, bound to the top level.
`timescale 1ns / 1ps
`include "gamepad_deadzone_and_edge_detect_top_macros.svh"
module gdz_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input gdz_pkg::out_t out_data
);

    logic absent_clean;
    logic conn_clean;

    // Fields that must be zero on an absent pad, and on a new connection
    assign absent_clean = !out_data.just_connected && (out_data.active_pad == 2'd0) &&
                          (out_data.press_edges == 4'd0) &&
                          (out_data.left_magnitude == 15'd0) &&
                          (out_data.right_magnitude == 15'd0);
    assign conn_clean   = (out_data.press_edges == 4'd0) && !out_data.just_disconnected;

    // A stalled result beat holds
    `GDZ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // One item at a time: busy right after an accepted beat
    `GDZ_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)
    // Absent pad gives an all-zero result apart from the disconnect flag
    `GDZ_ASSERT_IMP(a_absent, out_valid && !out_data.is_connected, absent_clean)
    // A new connection never reports press edges
    `GDZ_ASSERT_IMP(a_conn_edges, out_valid && out_data.just_connected, conn_clean)

endmodule

bind gamepad_deadzone_and_edge_detect_top gdz_checker u_gdz_checker (.*);
